FILE: sv/fpad_pkg.sv
// fpad_pkg: shared types and constants for the flight phase apogee detector
// no dependencies; used by fpad_tracker and the top-level wrapper
package fpad_pkg;

  // threshold register width and reset value (centimeters)
  localparam int unsigned THR_W     = 20;
  localparam logic [THR_W-1:0] THR_RESET = 20'd1000;

  // configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL = 1'd1;

  // flight phase codes
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_REC   = 2'd1,
    PH_RECOV = 2'd2
  } phase_t;

  // handshake control between the input register and the tracker
  typedef struct packed {
    logic valid;    // input register holds a beat
    logic advance;  // result register can take a beat this cycle
  } stage_ctrl_t;

endpackage

FILE: sv/fpad_if.sv
// fpad_if: valid/ready stream interfaces for samples and results
// depends on nothing; widths follow the altitude width parameter
interface fpad_in_if #(
  parameter int unsigned ALT_WIDTH = 24
);
  logic                 valid;
  logic                 ready;
  logic                 button_level;
  logic [ALT_WIDTH-1:0] altitude;

  modport source (output valid, output button_level, output altitude, input ready);
  modport sink   (input valid, input button_level, input altitude, output ready);
endinterface

interface fpad_out_if #(
  parameter int unsigned ALT_WIDTH = 24
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           phase;
  logic                 ascended;
  logic                 descending;
  logic [ALT_WIDTH-1:0] min_altitude;
  logic [ALT_WIDTH-1:0] max_altitude;

  modport source (output valid, output phase, output ascended, output descending,
                  output min_altitude, output max_altitude, input ready);
  modport sink   (input valid, input phase, input ascended, input descending,
                  input min_altitude, input max_altitude, output ready);
endinterface

FILE: sv/fpad_in_reg.sv
// fpad_in_reg: input register for sample beats
// depends on fpad_in_if
module fpad_in_reg #(
  parameter int unsigned ALT_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  fpad_in_if.sink              samples,
  input  logic                 advance,
  output logic                 valid,
  output logic                 button_level,
  output logic [ALT_WIDTH-1:0] altitude
);

  // take a new beat when empty or when the held one moves on
  assign samples.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (samples.ready) begin
      valid <= samples.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      button_level <= samples.button_level;
      altitude     <= samples.altitude;
    end
  end

endmodule

FILE: sv/fpad_tracker.sv
// fpad_tracker: flight state, threshold registers and single-pass update logic
// depends on fpad_pkg
module fpad_tracker #(
  parameter int unsigned ALT_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fpad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpad_pkg::THR_W-1:0]     cfg_data,
  input  fpad_pkg::stage_ctrl_t          ctrl,
  input  logic                           button_level,
  input  logic [ALT_WIDTH-1:0]           altitude,
  output fpad_pkg::phase_t               phase_next,
  output logic                           ascend_next,
  output logic                           descend_next,
  output logic [ALT_WIDTH-1:0]           min_next,
  output logic [ALT_WIDTH-1:0]           max_next
);

  // wide enough for a sample plus a threshold without wrap
  localparam int unsigned SW =
    ((ALT_WIDTH > fpad_pkg::THR_W) ? ALT_WIDTH : fpad_pkg::THR_W) + 2;

  function automatic logic signed [SW-1:0] sx(input logic [ALT_WIDTH-1:0] v);
    sx = {{(SW-ALT_WIDTH){v[ALT_WIDTH-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] zx(input logic [fpad_pkg::THR_W-1:0] v);
    zx = {{(SW-fpad_pkg::THR_W){1'b0}}, v};
  endfunction

  logic [fpad_pkg::THR_W-1:0] rise_threshold;
  logic [fpad_pkg::THR_W-1:0] fall_threshold;

  fpad_pkg::phase_t     phase;
  logic                 armed;
  logic                 ascend_flag;
  logic                 descend_flag;
  logic [ALT_WIDTH-1:0] min_alt;
  logic [ALT_WIDTH-1:0] max_alt;
  logic                 armed_next;
  logic                 fire;

  assign fire = ctrl.valid && ctrl.advance;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold <= fpad_pkg::THR_RESET;
      fall_threshold <= fpad_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpad_pkg::REG_RISE: rise_threshold <= cfg_data;
        fpad_pkg::REG_FALL: fall_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // update in the order of the flight rules
  always_comb begin
    phase_next   = phase;
    armed_next   = armed;
    ascend_next  = ascend_flag;
    descend_next = descend_flag;
    min_next     = min_alt;
    max_next     = max_alt;
    if (!button_level && phase == fpad_pkg::PH_WAIT) begin
      phase_next = fpad_pkg::PH_REC;
    end
    if (phase_next == fpad_pkg::PH_REC) begin
      // first sample seeds the minimum
      if (!armed) begin
        min_next   = altitude;
        armed_next = 1'b1;
      end
      if ($signed(altitude) < $signed(min_next)) begin
        min_next = altitude;
      end
      if (!ascend_next) begin
        max_next = '0;
      end
      if (!ascend_next && (sx(altitude) > sx(min_next) + zx(rise_threshold))) begin
        ascend_next = 1'b1;
      end
      // zero maximum means unset
      if (ascend_next && max_next == '0) begin
        max_next = altitude;
      end
      if (ascend_next && ($signed(altitude) > $signed(max_next))) begin
        max_next = altitude;
      end
      if (ascend_next && (sx(altitude) + zx(fall_threshold) < sx(max_next))) begin
        descend_next = 1'b1;
        ascend_next  = 1'b0;
        phase_next   = fpad_pkg::PH_RECOV;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fpad_pkg::PH_WAIT;
      armed        <= 1'b0;
      ascend_flag  <= 1'b0;
      descend_flag <= 1'b0;
      min_alt      <= '0;
      max_alt      <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      armed        <= armed_next;
      ascend_flag  <= ascend_next;
      descend_flag <= descend_next;
      min_alt      <= min_next;
      max_alt      <= max_next;
    end
  end

  // recovery is terminal
  a_recov_holds: assert property (@(posedge clk) disable iff (rst)
    phase == fpad_pkg::PH_RECOV |=> phase == fpad_pkg::PH_RECOV)
    else $error("left recovery phase");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ascend_flag && descend_flag))
    else $error("ascent and descent both flagged");

  a_max_needs_ascent: assert property (@(posedge clk) disable iff (rst)
    max_alt != '0 |-> (ascend_flag || descend_flag))
    else $error("maximum set before ascent");

  a_armed_not_waiting: assert property (@(posedge clk) disable iff (rst)
    armed |-> phase != fpad_pkg::PH_WAIT)
    else $error("armed while waiting");

endmodule

FILE: sv/flight_phase_apogee_detector_top.sv
// flight_phase_apogee_detector_top: stream wrapper with input and result registers
// depends on fpad_pkg, fpad_if, fpad_in_reg, fpad_tracker
//
// Takes one beat per clock: a beat is accepted every cycle as long as results
// are taken; each beat passes through the input register, one pass of
// compare-and-update logic and the result register. The flight state updates in
// that single pass, so consecutive samples need no spacing. The user must write
// thresholds via cfg_we/cfg_index/cfg_data while idle; the block does not check.
module flight_phase_apogee_detector_top #(
  parameter int unsigned ALT_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  fpad_in_if.sink                        samples,
  fpad_out_if.source                     results,
  input  logic                           cfg_we,
  input  logic [fpad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpad_pkg::THR_W-1:0]     cfg_data
);

  fpad_pkg::stage_ctrl_t ctrl;
  logic                  hold_valid;
  logic                  hold_button;
  logic [ALT_WIDTH-1:0]  hold_alt;
  fpad_pkg::phase_t      phase_next;
  logic                  ascend_next;
  logic                  descend_next;
  logic [ALT_WIDTH-1:0]  min_next;
  logic [ALT_WIDTH-1:0]  max_next;

  // result register frees up when empty or taken
  assign ctrl.valid   = hold_valid;
  assign ctrl.advance = !results.valid || results.ready;

  fpad_in_reg #(.ALT_WIDTH(ALT_WIDTH)) u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .advance      (ctrl.advance),
    .valid        (hold_valid),
    .button_level (hold_button),
    .altitude     (hold_alt)
  );

  fpad_tracker #(.ALT_WIDTH(ALT_WIDTH)) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctrl         (ctrl),
    .button_level (hold_button),
    .altitude     (hold_alt),
    .phase_next   (phase_next),
    .ascend_next  (ascend_next),
    .descend_next (descend_next),
    .min_next     (min_next),
    .max_next     (max_next)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ctrl.advance) begin
      results.valid <= hold_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.advance && hold_valid) begin
      results.phase        <= 2'(phase_next);
      results.ascended     <= ascend_next;
      results.descending   <= descend_next;
      results.min_altitude <= min_next;
      results.max_altitude <= max_next;
    end
  end

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (results.valid && !results.ready))
    else $error("input stalled without output backpressure");

  a_descent_recov: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.descending ==
                       (results.phase == 2'(fpad_pkg::PH_RECOV))))
    else $error("descent flag and recovery phase disagree");

endmodule
